// ----- hdl/btbf_pkg.sv -----
// Shared types and constants for the bottom-up tape box finder.
`default_nettype none

package btbf_pkg;

  localparam int MAX_DIM  = 2048;
  localparam int CNT_W    = 16;
  localparam int COORD_W  = 11;
  localparam int DIM_W    = 13;
  localparam int SPAN_W   = 14;

  localparam logic [DIM_W-1:0] MAX_DIM_C   = DIM_W'(MAX_DIM);
  localparam logic [5:0]       BOX_HEIGHT  = 6'd60;
  localparam logic [11:0]      Y_OFFSET    = 12'd70;

  localparam logic [11:0]      WIDTH_RST   = 12'd640;
  localparam logic [11:0]      HEIGHT_RST  = 12'd480;
  localparam logic [10:0]      SKIP_RST    = 11'd0;
  localparam logic [15:0]      THRESH_RST  = 16'd200;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH     = 2'd0,
    CFG_IMAGE_HEIGHT    = 2'd1,
    CFG_SKIP_ROWS       = 2'd2,
    CFG_COUNT_THRESHOLD = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]         chan_a;
    logic [7:0]         chan_b;
    logic [7:0]         chan_c;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic               frame_end;
  } pixel_t;

  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] box_x;
    logic signed [11:0] box_y;
    logic [COORD_W-1:0] box_width;
    logic [5:0]         box_height;
  } box_t;

endpackage

`default_nettype wire

// ----- hdl/btbf_pixel_if.sv -----
// Pixel stream channel: valid/ready handshake with one pixel item.
`default_nettype none

interface btbf_pixel_if
  import btbf_pkg::*;
;
  logic   valid;
  logic   ready;
  pixel_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/btbf_box_if.sv -----
// Result channel: valid/ready handshake with one box item.
`default_nettype none

interface btbf_box_if
  import btbf_pkg::*;
;
  logic valid;
  logic ready;
  box_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/bottom_up_tape_box_finder.sv -----
// Bottom-up tape box finder: scans a thresholded frame and reports one box per frame.
//
// Channels: in_pix carries pixels in scan order (bottom row first, left to right),
// out_box carries at most one item per frame: the box, or a not-found item at
// frame_end. cfg_we/cfg_idx/cfg_wdata write one of the four setup registers, chosen by cfg_idx.
// An accepted pixel is held in the input register, then the count, window check
// and run measurement run in one pass and the result lands in the output register.
// Throughput is one pixel per cycle while the receiver does not stall out_box.
// When the receiver stalls, the output register holds its item; the input register
// still takes one more pixel, then in_pix.ready drops until the output drains.
// Reset (synchronous, rst_n low) empties both registers, returns the setup
// registers to width 640, height 480, skip 0, threshold 200, and clears the
// frame state to searching with a zero count.
`default_nettype none

module bottom_up_tape_box_finder
  import btbf_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  btbf_pixel_if.sink         in_pix,
  btbf_box_if.source         out_box,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_idx,
  input  wire logic [15:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_MEASURE = 2'd1,
    PH_DONE    = 2'd2
  } phase_t;

  // setup registers
  logic [11:0]        image_width_r;
  logic [11:0]        image_height_r;
  logic [10:0]        skip_rows_r;
  logic [15:0]        count_threshold_r;

  // input register
  logic               s1_valid_r;
  pixel_t             s1_pix_r;

  // frame state
  phase_t             phase_r, phase_nxt;
  logic [CNT_W-1:0]   on_count_r, on_count_nxt;
  logic               prev_on_r, prev_on_nxt;
  logic [COORD_W-1:0] run_start_r, run_start_nxt;
  logic [COORD_W-1:0] run_row_r, run_row_nxt;

  // output register
  logic               out_valid_r;
  box_t               out_box_r;

  logic               out_free;
  logic               advance;
  logic               own;
  logic               on;
  logic               in_window;
  logic [DIM_W-1:0]   eff_width;
  logic [DIM_W-1:0]   row_top;
  logic signed [SPAN_W-1:0] last_s;
  logic signed [SPAN_W-1:0] col_s;
  logic signed [SPAN_W-1:0] clamp_s;
  logic signed [SPAN_W-1:0] end_col;
  logic signed [SPAN_W-1:0] span;
  logic               emit;
  logic               not_found;
  logic               res_valid;
  box_t               res_box;

  assign out_free     = !out_valid_r || out_box.ready;
  assign advance      = s1_valid_r && out_free;
  assign in_pix.ready = !s1_valid_r || out_free;

  assign out_box.valid = out_valid_r;
  assign out_box.data  = out_box_r;

  always_comb begin
    own       = |{s1_pix_r.chan_a, s1_pix_r.chan_b, s1_pix_r.chan_c};
    on        = (s1_pix_r.pixel_col == '0) ? own : prev_on_r;
    eff_width = ({1'b0, image_width_r} > MAX_DIM_C) ? MAX_DIM_C : {1'b0, image_width_r};
    last_s    = $signed({1'b0, eff_width}) - SPAN_W'(1);
    col_s     = $signed({3'b000, s1_pix_r.pixel_col});
    clamp_s   = (col_s > last_s) ? last_s : col_s;
    row_top   = {2'b00, s1_pix_r.pixel_row} + {2'b00, skip_rows_r} + DIM_W'(1);
    in_window = (s1_pix_r.pixel_row != '0) && (row_top <= {1'b0, image_height_r})
                && ({2'b00, s1_pix_r.pixel_col} < eff_width);

    on_count_nxt  = on_count_r;
    prev_on_nxt   = own;
    phase_nxt     = phase_r;
    run_start_nxt = run_start_r;
    run_row_nxt   = run_row_r;
    emit          = 1'b0;
    not_found     = 1'b0;
    end_col       = last_s;

    unique case (phase_r)
      PH_SEARCH: begin
        if (in_window && on) begin
          if (on_count_r < count_threshold_r) begin
            on_count_nxt = on_count_r + CNT_W'(1);
          end else begin
            run_start_nxt = s1_pix_r.pixel_col;
            run_row_nxt   = s1_pix_r.pixel_row;
            if (col_s >= last_s) begin
              emit      = 1'b1;
              end_col   = col_s;
              phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_MEASURE;
            end
          end
        end
      end
      PH_MEASURE: begin
        // a pixel of another row, or at or left of the start, closes the run at the row end
        if (s1_pix_r.pixel_row != run_row_r || s1_pix_r.pixel_col <= run_start_r) begin
          emit      = 1'b1;
          end_col   = last_s;
          phase_nxt = PH_DONE;
        end else if (!on || clamp_s >= last_s) begin
          emit      = 1'b1;
          end_col   = clamp_s;
          phase_nxt = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    if (s1_pix_r.frame_end) begin
      if (!emit) begin
        if (phase_nxt == PH_MEASURE) begin
          emit    = 1'b1;
          end_col = last_s;
        end else if (phase_nxt == PH_SEARCH) begin
          not_found = 1'b1;
        end
      end
      on_count_nxt = '0;
      prev_on_nxt  = 1'b0;
      phase_nxt    = PH_SEARCH;
    end

    span      = end_col - $signed({3'b000, run_start_nxt});
    res_valid = emit || not_found;

    res_box            = '0;
    if (emit) begin
      res_box.found      = 1'b1;
      res_box.box_x      = run_start_nxt;
      res_box.box_y      = $signed({1'b0, run_row_nxt} - Y_OFFSET);
      res_box.box_width  = span[SPAN_W-1] ? '0 : span[COORD_W-1:0];
      res_box.box_height = BOX_HEIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r     <= WIDTH_RST;
      image_height_r    <= HEIGHT_RST;
      skip_rows_r       <= SKIP_RST;
      count_threshold_r <= THRESH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_IMAGE_WIDTH:     image_width_r     <= cfg_wdata[11:0];
        CFG_IMAGE_HEIGHT:    image_height_r    <= cfg_wdata[11:0];
        CFG_SKIP_ROWS:       skip_rows_r       <= cfg_wdata[10:0];
        CFG_COUNT_THRESHOLD: count_threshold_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_SEARCH;
      on_count_r  <= '0;
      prev_on_r   <= 1'b0;
      run_start_r <= '0;
      run_row_r   <= '0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= advance && res_valid;
      end
      if (advance) begin
        phase_r     <= phase_nxt;
        on_count_r  <= on_count_nxt;
        prev_on_r   <= prev_on_nxt;
        run_start_r <= run_start_nxt;
        run_row_r   <= run_row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pix.valid && in_pix.ready) begin
      s1_pix_r <= in_pix.data;
    end
    if (advance && res_valid) begin
      out_box_r <= res_box;
    end
  end

endmodule

`default_nettype wire

// ----- sim/bottom_up_tape_box_finder_tb.sv -----
// Self-checking testbench for the bottom-up tape box finder: directed table, then random frames.
module bottom_up_tape_box_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btbf_pkg::*;

  typedef enum logic [1:0] {SEARCHING, MEASURING, REPORTED} scan_phase_t;

  typedef struct {
    bit         is_cfg;
    cfg_idx_t   idx;
    logic [15:0] val;
    pixel_t     pix;
    bit         known;
    box_t       known_box;
  } step_t;

  localparam box_t NO_BOX = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  cfg_idx_t cfg_idx;
  logic [15:0] cfg_wdata;

  btbf_pixel_if pix_bus ();
  btbf_box_if   box_bus ();

  bottom_up_tape_box_finder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (pix_bus),
    .out_box   (box_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // predictor copy of the setup registers and frame state
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  logic [10:0] skip_reg;
  logic [15:0] thresh_reg;
  logic [15:0] lit_count;
  bit          prev_lit;
  scan_phase_t scan_phase;
  logic [10:0] run_col;
  logic [10:0] run_line;

  box_t boxes_due[$];
  int   mismatches = 0;
  int   pixels_sent = 0;
  int   src_gap_max = 2;
  int   sink_stall_max = 2;
  int   sink_hold;

  function automatic box_t close_run(int end_col);
    box_t b;
    int span;
    span = end_col - int'(run_col);
    if (span < 0) span = 0;
    b.found      = 1'b1;
    b.box_x      = run_col;
    b.box_y      = 12'(int'(run_line) - int'(Y_OFFSET));
    b.box_width  = 11'(span);
    b.box_height = BOX_HEIGHT;
    scan_phase   = REPORTED;
    return b;
  endfunction

  function automatic bit predict_box(input pixel_t p, output box_t b);
    bit own;
    bit on;
    bit in_win;
    bit got;
    int row;
    int col;
    int wid;
    int last;
    int c;
    own    = (p.chan_a | p.chan_b | p.chan_c) != 0;
    row    = p.pixel_row;
    col    = p.pixel_col;
    wid    = (int'(width_reg) > MAX_DIM) ? MAX_DIM : int'(width_reg);
    last   = wid - 1;
    in_win = row >= 1 && row + int'(skip_reg) <= int'(height_reg) - 1 && col < wid;
    // a pixel is lit by its left neighbour, except in column 0
    on     = (col == 0) ? own : prev_lit;
    got    = 1'b0;
    b      = NO_BOX;
    case (scan_phase)
      SEARCHING: begin
        if (in_win && on) begin
          if (lit_count < thresh_reg) begin
            lit_count++;
          end else begin
            run_col  = 11'(col);
            run_line = 11'(row);
            if (col >= last) begin
              b   = close_run(col);
              got = 1'b1;
            end else begin
              scan_phase = MEASURING;
            end
          end
        end
      end
      MEASURING: begin
        // out-of-order pixel closes the run at the row end
        if (row != int'(run_line) || col <= int'(run_col)) begin
          b   = close_run(last);
          got = 1'b1;
        end else begin
          c = (col > last) ? last : col;
          if (!on || c >= last) begin
            b   = close_run(c);
            got = 1'b1;
          end
        end
      end
      default: ;
    endcase
    prev_lit = own;
    if (p.frame_end) begin
      if (!got && scan_phase == MEASURING) begin
        b   = close_run(last);
        got = 1'b1;
      end else if (!got && scan_phase == SEARCHING) begin
        b   = NO_BOX;
        got = 1'b1;
      end
      lit_count  = '0;
      prev_lit   = 1'b0;
      scan_phase = SEARCHING;
    end
    return got;
  endfunction

  function automatic void cmp_field(string name, logic signed [12:0] want,
                                    logic signed [12:0] got);
    if (got !== want) begin
      $display("%0t box %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int pick3(int a, int b, int c);
    case ($urandom_range(0, 2))
      0: return a;
      1: return b;
      default: return c;
    endcase
  endfunction

  function automatic pixel_t random_pixel(int density);
    pixel_t p;
    p = '0;
    if ($urandom_range(1, 10) <= density) begin
      p.chan_a = 8'($urandom);
      p.chan_b = 8'($urandom);
      p.chan_c = 8'($urandom);
      if ((p.chan_a | p.chan_b | p.chan_c) == 0) p.chan_b = 8'd1;
    end
    p.pixel_row = 11'($urandom_range(0, 2047));
    p.pixel_col = 11'($urandom_range(0, 2047));
    return p;
  endfunction

  function automatic step_t px(int a, int b, int c, int row, int col, bit fe);
    step_t s;
    s.is_cfg    = 1'b0;
    s.idx       = CFG_IMAGE_WIDTH;
    s.val       = '0;
    s.pix       = '{8'(a), 8'(b), 8'(c), 11'(row), 11'(col), fe};
    s.known     = 1'b0;
    s.known_box = NO_BOX;
    return s;
  endfunction

  function automatic step_t with_box(step_t s, box_t b);
    s.known     = 1'b1;
    s.known_box = b;
    return s;
  endfunction

  function automatic step_t reg_wr(cfg_idx_t idx, int val);
    step_t s;
    s.is_cfg    = 1'b1;
    s.idx       = idx;
    s.val       = 16'(val);
    s.pix       = '0;
    s.known     = 1'b0;
    s.known_box = NO_BOX;
    return s;
  endfunction

  task automatic push_pixel(input pixel_t p, input bit known, input box_t known_box);
    int gap;
    bit got;
    box_t b;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.data  <= p;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
    got = predict_box(p, b);
    if (known) boxes_due.push_back(known_box);
    else if (got) boxes_due.push_back(b);
  endtask

  // wait until every expected item is out and the pipeline has flushed
  task automatic drain_block();
    pix_bus.valid <= 1'b0;
    while (boxes_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int val);
    drain_block();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= 16'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg  = 12'(val);
      CFG_IMAGE_HEIGHT: height_reg = 12'(val);
      CFG_SKIP_ROWS:    skip_reg   = 11'(val);
      default:          thresh_reg = 16'(val);
    endcase
  endtask

  always @(posedge clk) begin : box_sink
    int draw;
    if (!rst_n) begin
      box_bus.ready <= 1'b0;
      sink_hold     <= 0;
    end else if (box_bus.valid && box_bus.ready) begin
      draw = $urandom_range(0, sink_stall_max);
      sink_hold     <= draw;
      box_bus.ready <= (draw == 0);
    end else if (sink_hold > 1) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_hold     <= 0;
      box_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : box_check
    box_t want;
    if (rst_n && box_bus.valid && box_bus.ready) begin
      if (boxes_due.size() == 0) begin
        $display("%0t box item with none expected: expected nothing, got %p",
                 $time, box_bus.data);
        mismatches++;
      end else begin
        want = boxes_due.pop_front();
        cmp_field("found",  want.found,      box_bus.data.found);
        cmp_field("x",      want.box_x,      box_bus.data.box_x);
        cmp_field("y",      want.box_y,      box_bus.data.box_y);
        cmp_field("width",  want.box_width,  box_bus.data.box_width);
        cmp_field("height", want.box_height, box_bus.data.box_height);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    step_t  plan[$];
    pixel_t p;
    bit     wide;
    int     w, h, skip, thr, rows_top, frames, style, density, n, k, cut, r, c;

    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_IMAGE_WIDTH;
    cfg_wdata     <= '0;
    pix_bus.valid <= 1'b0;
    pix_bus.data  <= '0;
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    skip_reg   = SKIP_RST;
    thresh_reg = THRESH_RST;
    lit_count  = '0;
    prev_lit   = 1'b0;
    scan_phase = SEARCHING;
    run_col    = '0;
    run_line   = '0;

    // row 0 is never scanned: frame ends empty
    plan.push_back(with_box(px(0, 0, 0, 0, 0, 1), NO_BOX));
    plan.push_back(px(255, 0, 0, 5, 0, 0));
    plan.push_back(with_box(px(0, 0, 0, 5, 1, 1), NO_BOX));
    plan.push_back(reg_wr(CFG_COUNT_THRESHOLD, 0));
    plan.push_back(reg_wr(CFG_IMAGE_WIDTH, 4));
    plan.push_back(reg_wr(CFG_IMAGE_HEIGHT, 3));
    // run ends at first dark pixel
    plan.push_back(px(255, 0, 0, 2, 0, 0));
    plan.push_back(px(0, 0, 0, 2, 1, 0));
    plan.push_back(with_box(px(0, 0, 0, 2, 2, 0),
                            box_t'{1'b1, 11'd0, -12'sd68, 11'd2, BOX_HEIGHT}));
    plan.push_back(px(0, 0, 0, 1, 3, 1));
    // run reaching the last column
    plan.push_back(px(0, 1, 0, 1, 0, 0));
    plan.push_back(px(0, 0, 1, 1, 1, 0));
    plan.push_back(px(1, 1, 1, 1, 2, 0));
    plan.push_back(px(0, 0, 0, 1, 3, 1));
    // run broken by a pixel of another row
    plan.push_back(px(255, 255, 255, 2, 0, 0));
    plan.push_back(px(0, 0, 0, 1, 0, 1));
    // column beyond row end while measuring
    plan.push_back(px(0, 0, 128, 2, 0, 0));
    plan.push_back(px(0, 0, 0, 2, 1000, 0));
    plan.push_back(px(0, 0, 0, 2, 2, 1));
    // frame end while measuring
    plan.push_back(px(1, 0, 0, 2, 0, 0));
    plan.push_back(px(0, 0, 0, 2, 1, 1));
    plan.push_back(reg_wr(CFG_COUNT_THRESHOLD, 1));
    // run starting on the last column
    plan.push_back(px(2, 0, 0, 2, 0, 0));
    plan.push_back(with_box(px(0, 0, 0, 2, 3, 0),
                            box_t'{1'b1, 11'd3, -12'sd68, 11'd0, BOX_HEIGHT}));
    plan.push_back(px(0, 0, 0, 1, 0, 1));
    plan.push_back(reg_wr(CFG_SKIP_ROWS, 1));
    // row above the scan window
    plan.push_back(with_box(px(255, 255, 255, 2, 0, 1), NO_BOX));
    plan.push_back(reg_wr(CFG_IMAGE_WIDTH, 2048));
    plan.push_back(reg_wr(CFG_IMAGE_HEIGHT, 2048));
    plan.push_back(reg_wr(CFG_SKIP_ROWS, 0));
    plan.push_back(reg_wr(CFG_COUNT_THRESHOLD, 65535));
    plan.push_back(with_box(px(255, 255, 255, 2047, 2047, 1), NO_BOX));
    plan.push_back(reg_wr(CFG_COUNT_THRESHOLD, 0));
    plan.push_back(px(255, 255, 255, 2047, 0, 0));
    plan.push_back(with_box(px(0, 0, 0, 2047, 2047, 1),
                            box_t'{1'b1, 11'd0, 12'sd1977, 11'd2047, BOX_HEIGHT}));
    plan.push_back(reg_wr(CFG_SKIP_ROWS, 2047));
    plan.push_back(with_box(px(255, 0, 0, 1, 0, 1), NO_BOX));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_reg(plan[i].idx, plan[i].val);
      else push_pixel(plan[i].pix, plan[i].known, plan[i].known_box);
    end

    while (pixels_sent < 550) begin
      wide = ($urandom_range(0, 5) == 0);
      if (wide) begin
        w    = pick3(2, 2048, $urandom_range(2, 2048));
        h    = pick3(2, 2048, $urandom_range(2, 2048));
        skip = pick3(0, 2047, $urandom_range(0, 20));
        thr  = pick3(0, 65535, $urandom_range(0, 20));
      end else begin
        w    = $urandom_range(2, 8);
        h    = $urandom_range(2, 6);
        skip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0;
        thr  = $urandom_range(0, 6);
      end
      write_reg(CFG_IMAGE_WIDTH, w);
      write_reg(CFG_IMAGE_HEIGHT, h);
      write_reg(CFG_SKIP_ROWS, skip);
      write_reg(CFG_COUNT_THRESHOLD, thr);
      src_gap_max    = pick3(0, 3, 16);
      sink_stall_max = pick3(0, 3, 16);
      rows_top = h - 1 - skip;
      frames   = $urandom_range(1, 4);
      repeat (frames) begin
        style   = $urandom_range(0, 7);
        density = $urandom_range(0, 10);
        if (style == 7 || rows_top < 1 || rows_top * w > 48) begin
          // scattered pixels, arbitrary coordinates
          n = $urandom_range(1, 12);
          for (k = 1; k <= n; k++) begin
            p = random_pixel(density);
            p.frame_end = (k == n);
            push_pixel(p, 1'b0, NO_BOX);
          end
        end else begin
          // scan-order frame; styles 5 and 6 truncate it and scramble some pixels
          cut = (style >= 5) ? $urandom_range(1, rows_top * w) : rows_top * w;
          k = 0;
          for (r = rows_top; r >= 1; r--) begin
            for (c = 0; c < w; c++) begin
              if (k < cut) begin
                p = random_pixel(density);
                if (!(style >= 5 && $urandom_range(0, 4) == 0)) begin
                  p.pixel_row = 11'(r);
                  p.pixel_col = 11'(c);
                end
                k++;
                p.frame_end = (k == cut);
                push_pixel(p, 1'b0, NO_BOX);
              end
            end
          end
        end
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
